@@ hdl/keyed_value_store_defines.svh @@
// ----------------------------------------------------------------------------
// keyed_value_store_defines
// assertion macros for the checker file of the key/value table
// ----------------------------------------------------------------------------
`ifndef KEYED_VALUE_STORE_DEFINES_SVH
`define KEYED_VALUE_STORE_DEFINES_SVH

// property checked only out of reset
`define KVS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked in every cycle, reset included
`define KVS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hdl/kvs_pkg.sv @@
// ----------------------------------------------------------------------------
// kvs_pkg
// types, codes and constants of the key/value table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvs_pkg;

    localparam int DEF_ENTRIES = 64;
    localparam int KEY_W       = 8;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 3;
    localparam int OUT_CNT_W   = 7;

    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_HIT      = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISS     = 3'd4;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [VAL_W-1:0]     value_out;
        logic [OUT_CNT_W-1:0] entry_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic              start;
        logic              scan;
        logic              wr_upd;
        logic              wr_ins;
        logic              val_rd;
        logic              set_status;
        logic [STAT_W-1:0] status;
        logic              load_out;
    } kvs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic exhausted;
        logic full;
        logic is_read;
        logic out_free;
    } kvs_sts_t;

endpackage

@@ hdl/keyed_value_store.sv @@
// ----------------------------------------------------------------------------
// keyed_value_store
// small associative table mapping an 8-bit key to a 32-bit value word
// ----------------------------------------------------------------------------
// One request is handled at a time. The key memory is walked one entry per
// cycle from the oldest entry, through a registered read, until the first
// match or the last held entry. The status is set when the walk ends, or with
// the value memory read on a read hit. The response is then loaded into the
// output register. The next word is accepted in the cycle after the response
// is loaded, even while it waits to be taken; a response still waiting stalls
// only the final load. Entries are never removed; a write of a new key to a
// full table is dropped and reported. value_out is zero for every status
// except read hit.
`timescale 1ns / 1ps

module keyed_value_store #(
    parameter int ENTRIES = kvs_pkg::DEF_ENTRIES
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  kvs_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output kvs_pkg::rsp_t m_data
);
    import kvs_pkg::*;

    kvs_cmd_t cmd;
    kvs_sts_t sts;

    kvs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    kvs_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ hdl/kvs_ctrl.sv @@
// ----------------------------------------------------------------------------
// kvs_ctrl
// sequencer for one request: scan, write or value read, then response
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  kvs_pkg::kvs_sts_t sts,
    output kvs_pkg::kvs_cmd_t cmd
);
    import kvs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_VREAD = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.status     = ST_MISS;
        cmd.start      = s_valid && s_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = !sts.match && !sts.exhausted;
                priority if (sts.match) begin
                    if (sts.is_read) begin
                        state_next = S_VREAD;
                    end else begin
                        cmd.wr_upd     = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_UPDATED;
                        state_next     = S_FIN;
                    end
                end else if (sts.exhausted) begin
                    cmd.set_status = 1'b1;
                    state_next     = S_FIN;
                    priority if (sts.is_read) begin
                        cmd.status = ST_MISS;
                    end else if (sts.full) begin
                        cmd.status = ST_FULL;
                    end else begin
                        cmd.wr_ins = 1'b1;
                        cmd.status = ST_INSERTED;
                    end
                end else begin
                    // still walking the held entries
                    state_next = S_SCAN;
                end
            end
            S_VREAD: begin
                cmd.val_rd     = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_HIT;
                state_next     = S_FIN;
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/kvs_dp.sv @@
// ----------------------------------------------------------------------------
// kvs_dp
// key and value memories, scan pipeline, entry count and response register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvs_dp #(
    parameter int ENTRIES = kvs_pkg::DEF_ENTRIES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  kvs_pkg::req_t     s_data,
    input  kvs_pkg::kvs_cmd_t cmd,
    output kvs_pkg::kvs_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output kvs_pkg::rsp_t     m_data
);
    import kvs_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(ENTRIES);

    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [VAL_W-1:0] val_mem [ENTRIES];

    req_t              req_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     addr_reg;
    logic [IW-1:0]     cmp_idx_reg;
    logic              rd_vld_reg;
    logic [KEY_W-1:0]  key_rd_reg;
    logic [VAL_W-1:0]  val_rd_reg;
    logic [STAT_W-1:0] status_reg;
    logic              m_valid_reg;
    rsp_t              m_data_reg;
    logic              issue;

    // a read is issued only for entries that were written
    assign issue = cmd.scan && (addr_reg < cnt_reg);

    assign sts.match     = rd_vld_reg && (key_rd_reg == req_reg.key);
    assign sts.exhausted = !rd_vld_reg && (addr_reg >= cnt_reg);
    assign sts.full      = (cnt_reg >= CNT_MAX);
    assign sts.is_read   = (req_reg.req_type == REQ_READ);
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_reg <= s_data;
        end
        if (issue) begin
            key_rd_reg  <= key_mem[addr_reg[IW-1:0]];
            cmp_idx_reg <= addr_reg[IW-1:0];
        end
        if (cmd.wr_ins) begin
            key_mem[cnt_reg[IW-1:0]] <= req_reg.key;
            val_mem[cnt_reg[IW-1:0]] <= req_reg.value_in;
        end else if (cmd.wr_upd) begin
            val_mem[cmp_idx_reg] <= req_reg.value_in;
        end
        if (cmd.val_rd) begin
            val_rd_reg <= val_mem[cmp_idx_reg];
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
        if (cmd.load_out) begin
            m_data_reg.status      <= status_reg;
            m_data_reg.value_out   <= (status_reg == ST_HIT) ? val_rd_reg : '0;
            m_data_reg.entry_count <= OUT_CNT_W'(cnt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_ins) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            priority if (cmd.start) begin
                addr_reg   <= '0;
                rd_vld_reg <= 1'b0;
            end else if (cmd.scan) begin
                rd_vld_reg <= issue;
                if (issue) begin
                    addr_reg <= addr_reg + 1'b1;
                end
            end else begin
                addr_reg   <= addr_reg;
                rd_vld_reg <= rd_vld_reg;
            end
            priority if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= m_valid_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hdl/kvs_checker.sv @@
// ----------------------------------------------------------------------------
// kvs_checker
// port-level checks of the key/value table, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyed_value_store_defines.svh"

module kvs_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input kvs_pkg::rsp_t m_data
);
    import kvs_pkg::*;

    // no response word right after reset
    `KVS_ASSERT_ALWAYS(a_rst_no_out, !aresetn |=> !m_valid, "response valid after reset")

    // a held response word keeps its contents
    `KVS_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "response changed while stalled")

    // value word only carries data on a read hit
    `KVS_ASSERT(a_val_zero, m_valid && (m_data.status != ST_HIT) |-> m_data.value_out == '0, "value_out nonzero without read hit")

    // one request in flight: no accept directly after an accept
    `KVS_ASSERT(a_one_req, s_valid && s_ready |=> !s_ready, "second word accepted while busy")

    // status code is one of the defined responses
    `KVS_ASSERT(a_status_ok, m_valid |-> m_data.status <= ST_MISS, "undefined status code")

endmodule

bind keyed_value_store kvs_checker u_kvs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/tb_keyed_value_store.sv @@
// ----------------------------------------------------------------------------
// tb_keyed_value_store
// self-checking bench for the key/value table: directed corners, random
// updates and reads on a partly filled table, a fill to capacity and traffic
// on the full table, each word checked against an in-bench table model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyed_value_store;
    import kvs_pkg::*;

    localparam int TABLE_DEPTH   = DEF_ENTRIES;
    localparam int CLK_HALF      = 10;
    localparam int MAX_GAP       = 14;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
    localparam int REPORT_LIMIT  = 40;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;

    // table model, updated when a request word is accepted
    logic [KEY_W-1:0] table_keys   [TABLE_DEPTH];
    logic [VAL_W-1:0] table_values [TABLE_DEPTH];
    int               table_count;

    rsp_t expected_words [$];
    int   error_count;
    bit   burst_mode;
    int   rx_stall;

    keyed_value_store #(
        .ENTRIES(TABLE_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int find_slot(input logic [KEY_W-1:0] k);
        for (int i = 0; i < table_count; i++) begin
            if (table_keys[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic rsp_t predict_response(input req_t w);
        rsp_t r;
        int   slot;
        slot = find_slot(w.key);
        r = '0;
        if (w.req_type == REQ_UPDATE) begin
            if (slot >= 0) begin
                table_values[slot] = w.value_in;
                r.status = ST_UPDATED;
            end else if (table_count < TABLE_DEPTH) begin
                table_keys[table_count]   = w.key;
                table_values[table_count] = w.value_in;
                table_count++;
                r.status = ST_INSERTED;
            end else begin
                r.status = ST_FULL;
            end
        end else if (slot >= 0) begin
            r.status    = ST_HIT;
            r.value_out = table_values[slot];
        end else begin
            r.status = ST_MISS;
        end
        r.entry_count = OUT_CNT_W'(table_count);
        return r;
    endfunction

    function automatic req_t make_request(input logic t, input logic [KEY_W-1:0] k,
                                          input logic [VAL_W-1:0] v);
        req_t w;
        w.req_type = t;
        w.key      = k;
        w.value_in = v;
        return w;
    endfunction

    // mostly random words, with the all-zero and all-one words mixed in
    function automatic logic [VAL_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return VAL_W'($urandom());
    endfunction

    function automatic logic [KEY_W-1:0] held_key();
        return table_keys[$urandom_range(0, table_count - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] absent_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom());
        while (find_slot(k) >= 0) k = KEY_W'($urandom());
        return k;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic send_request(input req_t w);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.push_back(predict_response(w));
    endtask

    task automatic hold_until_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (expected_words.size() == 0);
    endtask

    // result channel: stall drawn after every word taken
    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            m_ready  <= 1'b0;
            rx_stall = rx_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_words
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word status=%0d value=%h count=%0d",
                                          m_data.status, m_data.value_out,
                                          m_data.entry_count));
            end else begin
                want = expected_words.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_data.status, want.status));
                if (m_data.value_out !== want.value_out)
                    report_mismatch($sformatf("value_out %h, want %h",
                                              m_data.value_out, want.value_out));
                if (m_data.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              m_data.entry_count, want.entry_count));
            end
            rx_stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    task automatic test_directed_corners();
        send_request(make_request(REQ_READ,   8'h00, 32'hFFFF_FFFF)); // miss on empty table
        send_request(make_request(REQ_UPDATE, 8'h00, 32'h0000_0000));
        send_request(make_request(REQ_UPDATE, 8'hFF, 32'hFFFF_FFFF));
        send_request(make_request(REQ_READ,   8'h00, 32'h0000_0000));
        send_request(make_request(REQ_READ,   8'hFF, 32'h0000_0000));
        send_request(make_request(REQ_UPDATE, 8'hFF, 32'h0000_0000));
        send_request(make_request(REQ_READ,   8'hFF, 32'h1234_5678)); // value_in ignored
        // same key again must overwrite, never add a second entry
        send_request(make_request(REQ_UPDATE, 8'h00, 32'hA5A5_5A5A));
        send_request(make_request(REQ_READ,   8'h00, 32'h0000_0000));
        send_request(make_request(REQ_READ,   8'h80, 32'h0000_0000));
        send_request(make_request(REQ_READ,   8'h7F, 32'hFFFF_FFFF));
        send_request(make_request(REQ_UPDATE, 8'h7F, 32'h5A5A_A5A5));
        send_request(make_request(REQ_UPDATE, 8'h80, 32'h8000_0001));
        send_request(make_request(REQ_READ,   8'h7F, 32'h0000_0000));
        send_request(make_request(REQ_READ,   8'h80, 32'h0000_0000));
        send_request(make_request(REQ_UPDATE, 8'h01, 32'h0000_0001));
        send_request(make_request(REQ_READ,   8'h01, 32'h0000_0000));
    endtask

    task automatic test_random_partial(input int n_words);
        int               pick;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < n_words; i++) begin
            burst_mode = ((i / 40) % 4) == 2;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // keep some headroom so the fill test does the last inserts
                if (pick < 20 || table_count >= TABLE_DEPTH - 8) k = held_key();
                else k = absent_key();
                send_request(make_request(REQ_UPDATE, k, random_value()));
                if ($urandom_range(0, 1) == 1)
                    send_request(make_request(REQ_READ, k, random_value()));
            end else if (pick < 75) begin
                send_request(make_request(REQ_READ, held_key(), random_value()));
            end else begin
                send_request(make_request(REQ_READ, absent_key(), random_value()));
            end
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_fill_to_capacity();
        int               i;
        logic [KEY_W-1:0] k;
        i = 0;
        while (table_count < TABLE_DEPTH) begin
            burst_mode = ((i / 24) % 3) == 1;
            k = absent_key();
            send_request(make_request(REQ_UPDATE, k, random_value()));
            if ($urandom_range(0, 2) == 0)
                send_request(make_request(REQ_READ, k, random_value()));
            else if ($urandom_range(0, 4) == 0)
                send_request(make_request(REQ_READ, held_key(), random_value()));
            i++;
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_full_table(input int n_words);
        int pick;
        for (int i = 0; i < n_words; i++) begin
            burst_mode = ((i / 40) % 4) == 1;
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                send_request(make_request(REQ_UPDATE, absent_key(), random_value()));
            end else if (pick < 50) begin
                send_request(make_request(REQ_UPDATE, held_key(), random_value()));
            end else if (pick < 60) begin
                // newest entry: longest walk
                send_request(make_request(REQ_READ, table_keys[TABLE_DEPTH-1],
                                          random_value()));
            end else if (pick < 80) begin
                send_request(make_request(REQ_READ, held_key(), random_value()));
            end else begin
                send_request(make_request(REQ_READ, absent_key(), random_value()));
            end
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        rx_stall    = 0;
        error_count = 0;
        table_count = 0;
        burst_mode  = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_corners();
        hold_until_idle();
        test_random_partial(300);
        test_fill_to_capacity();
        hold_until_idle();
        test_full_table(300);
        hold_until_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/kvs_pkg.sv
hdl/kvs_ctrl.sv
hdl/kvs_dp.sv
hdl/keyed_value_store.sv
hdl/kvs_checker.sv
tb/tb_keyed_value_store.sv
